// ===== sv/separable_complex_scaler_macros.svh =====
// Assertion macros for the block's top-level module.
`ifndef SEPARABLE_COMPLEX_SCALER_MACROS_SVH
`define SEPARABLE_COMPLEX_SCALER_MACROS_SVH
`ifndef SYNTHESIS
`define SCS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("separable_complex_scaler: assertion failed");
`define SCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("separable_complex_scaler: assertion failed");
`else
`define SCS_ASSERT_SAME(lbl, ante, cons)
`define SCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/scs_pkg.sv =====
package scs_pkg;

    localparam int NUM_DIMS   = 3;
    localparam int MAX_EXTENT = 256;
    localparam int IDX_W      = $clog2(MAX_EXTENT);
    localparam int EXT_W      = IDX_W + 1;
    localparam int DIM_W      = 2;
    localparam int ADDR_W     = DIM_W + IDX_W;
    localparam int OFF_W      = 24;
    localparam int DATA_W     = 32;
    localparam int FAC_W      = DATA_W + 1;
    localparam int FRAC_BITS  = 27;

    localparam logic [2:0] REG_EXTENT0 = 3'd0;
    localparam logic [2:0] REG_EXTENT1 = 3'd1;
    localparam logic [2:0] REG_EXTENT2 = 3'd2;
    localparam logic [2:0] REG_STRIDE0 = 3'd3;
    localparam logic [2:0] REG_STRIDE1 = 3'd4;
    localparam logic [2:0] REG_STRIDE2 = 3'd5;
    localparam logic [2:0] REG_CONJ    = 3'd6;
    localparam logic [2:0] REG_ENABLE  = 3'd7;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef struct packed {
        logic [NUM_DIMS-1:0][EXT_W-1:0] extent;
        logic [NUM_DIMS-1:0][OFF_W-1:0] stride;
    } scs_geom_t;

endpackage

// ===== sv/scs_factor_ram.sv =====
module scs_factor_ram
(
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [scs_pkg::ADDR_W-1:0]          wr_addr,
    input  logic [2*scs_pkg::DATA_W-1:0]        wr_data,
    input  logic                                rd_en,
    input  logic [scs_pkg::ADDR_W-1:0]          rd_addr,
    output logic [2*scs_pkg::DATA_W-1:0]        rd_data
);

    logic [2*scs_pkg::DATA_W-1:0] mem [0:scs_pkg::NUM_DIMS*scs_pkg::MAX_EXTENT-1];
    logic [2*scs_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/scs_cmac.sv =====
module scs_cmac
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [scs_pkg::FAC_W-1:0]    a_re,
    input  logic signed [scs_pkg::FAC_W-1:0]    a_im,
    input  logic signed [scs_pkg::DATA_W-1:0]   b_re,
    input  logic signed [scs_pkg::DATA_W-1:0]   b_im,
    output logic                                busy,
    output logic                                done,
    output logic signed [scs_pkg::DATA_W-1:0]   res_re,
    output logic signed [scs_pkg::DATA_W-1:0]   res_im,
    output logic                                clip
);

    localparam int PROD_W = scs_pkg::FAC_W + scs_pkg::DATA_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int Q_W    = ACC_W - scs_pkg::FRAC_BITS;

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [2:0]                           step_reg;
    logic signed [scs_pkg::FAC_W-1:0]     a_re_reg;
    logic signed [scs_pkg::FAC_W-1:0]     a_im_reg;
    logic signed [scs_pkg::DATA_W-1:0]    b_re_reg;
    logic signed [scs_pkg::DATA_W-1:0]    b_im_reg;
    logic signed [PROD_W-1:0]             prod_reg;
    logic signed [ACC_W-1:0]              acc_re_reg;
    logic signed [ACC_W-1:0]              acc_im_reg;
    logic signed [scs_pkg::DATA_W-1:0]    res_re_reg;
    logic signed [scs_pkg::DATA_W-1:0]    res_im_reg;
    logic                                 clip_reg;

    logic signed [scs_pkg::FAC_W-1:0]     mul_a;
    logic signed [scs_pkg::DATA_W-1:0]    mul_b;
    logic signed [ACC_W-1:0]              prod_ext;
    logic signed [ACC_W-1:0]              half;
    logic signed [ACC_W-1:0]              rnd_re;
    logic signed [ACC_W-1:0]              rnd_im;
    logic signed [Q_W-1:0]                q_re;
    logic signed [Q_W-1:0]                q_im;
    logic                                 ovf_re;
    logic                                 ovf_im;
    logic signed [scs_pkg::DATA_W-1:0]    sat_re;
    logic signed [scs_pkg::DATA_W-1:0]    sat_im;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:
            begin
                mul_a = a_re_reg;
                mul_b = b_re_reg;
            end
            2'd1:
            begin
                mul_a = a_im_reg;
                mul_b = b_im_reg;
            end
            2'd2:
            begin
                mul_a = a_re_reg;
                mul_b = b_im_reg;
            end
            default:
            begin
                mul_a = a_im_reg;
                mul_b = b_re_reg;
            end
        endcase
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign half     = ACC_W'(1) <<< (scs_pkg::FRAC_BITS - 1);
    assign rnd_re   = acc_re_reg + half;
    assign rnd_im   = acc_im_reg + half;
    assign q_re     = Q_W'(rnd_re >>> scs_pkg::FRAC_BITS);
    assign q_im     = Q_W'(rnd_im >>> scs_pkg::FRAC_BITS);
    assign ovf_re   = (q_re[Q_W-1:scs_pkg::DATA_W-1] != '0)
                   && (q_re[Q_W-1:scs_pkg::DATA_W-1] != '1);
    assign ovf_im   = (q_im[Q_W-1:scs_pkg::DATA_W-1] != '0)
                   && (q_im[Q_W-1:scs_pkg::DATA_W-1] != '1);
    assign sat_re   = !ovf_re ? q_re[scs_pkg::DATA_W-1:0]
                    : (q_re[Q_W-1] ? {1'b1, {(scs_pkg::DATA_W-1){1'b0}}}
                                   : {1'b0, {(scs_pkg::DATA_W-1){1'b1}}});
    assign sat_im   = !ovf_im ? q_im[scs_pkg::DATA_W-1:0]
                    : (q_im[Q_W-1] ? {1'b1, {(scs_pkg::DATA_W-1){1'b0}}}
                                   : {1'b0, {(scs_pkg::DATA_W-1){1'b1}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_re_reg   <= a_re;
            a_im_reg   <= a_im;
            b_re_reg   <= b_re;
            b_im_reg   <= b_im;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg < 3'd4)
            begin
                prod_reg <= mul_a * mul_b;
            end
            case (step_reg)
                3'd1:    acc_re_reg <= acc_re_reg + prod_ext;
                3'd2:    acc_re_reg <= acc_re_reg - prod_ext;
                3'd3:    acc_im_reg <= acc_im_reg + prod_ext;
                3'd4:    acc_im_reg <= acc_im_reg + prod_ext;
                3'd5:
                begin
                    res_re_reg <= sat_re;
                    res_im_reg <= sat_im;
                    clip_reg   <= ovf_re || ovf_im;
                end
                default: ;
            endcase
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign res_re = res_re_reg;
    assign res_im = res_im_reg;
    assign clip   = clip_reg;

endmodule

// ===== sv/scs_index.sv =====
module scs_index
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            start,
    input  logic                                            restart,
    input  scs_pkg::scs_geom_t                              geom,
    output logic [scs_pkg::NUM_DIMS-1:0][scs_pkg::IDX_W-1:0] pos,
    output logic [scs_pkg::OFF_W-1:0]                       offset,
    output logic                                            last
);

    logic [scs_pkg::NUM_DIMS-1:0][scs_pkg::IDX_W-1:0] cnt_reg;
    logic [scs_pkg::NUM_DIMS-1:0][scs_pkg::IDX_W-1:0] cnt_next;
    logic [scs_pkg::NUM_DIMS-1:0][scs_pkg::IDX_W-1:0] pos_reg;
    logic [scs_pkg::NUM_DIMS-1:0][scs_pkg::IDX_W-1:0] pos_next;
    logic [scs_pkg::OFF_W-1:0]                        offset_reg;
    logic [scs_pkg::OFF_W-1:0]                        offset_next;
    logic                                             last_reg;
    logic                                             last_next;

    logic [scs_pkg::NUM_DIMS-1:0][scs_pkg::EXT_W-1:0] eff;
    logic [scs_pkg::NUM_DIMS-1:0][scs_pkg::IDX_W-1:0] cnt_eff;
    logic [scs_pkg::NUM_DIMS-1:0][scs_pkg::EXT_W-1:0] inc;
    logic [scs_pkg::NUM_DIMS-1:0]                     has_room;
    logic [scs_pkg::NUM_DIMS:0]                       carry;

    always_comb
    begin
        offset_next = '0;
        last_next   = 1'b1;
        carry[scs_pkg::NUM_DIMS] = 1'b1;
        for (int d = 0; d < scs_pkg::NUM_DIMS; d++)
        begin
            if (geom.extent[d] == '0)
            begin
                eff[d] = scs_pkg::EXT_W'(1);
            end
            else if (geom.extent[d] > scs_pkg::EXT_W'(scs_pkg::MAX_EXTENT))
            begin
                eff[d] = scs_pkg::EXT_W'(scs_pkg::MAX_EXTENT);
            end
            else
            begin
                eff[d] = geom.extent[d];
            end
            cnt_eff[d] = restart ? '0 : cnt_reg[d];
            if ({1'b0, cnt_eff[d]} >= eff[d])
            begin
                pos_next[d] = scs_pkg::IDX_W'(eff[d] - scs_pkg::EXT_W'(1));
            end
            else
            begin
                pos_next[d] = cnt_eff[d];
            end
            inc[d]      = {1'b0, pos_next[d]} + scs_pkg::EXT_W'(1);
            has_room[d] = inc[d] < eff[d];
            if (has_room[d])
            begin
                last_next = 1'b0;
            end
            offset_next = offset_next
                        + scs_pkg::OFF_W'(pos_next[d] * geom.stride[d]);
        end
        for (int d = scs_pkg::NUM_DIMS - 1; d >= 0; d--)
        begin
            if (carry[d+1])
            begin
                cnt_next[d] = has_room[d] ? inc[d][scs_pkg::IDX_W-1:0] : '0;
            end
            else
            begin
                cnt_next[d] = cnt_eff[d];
            end
            carry[d] = carry[d+1] && !has_room[d];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            last_reg   <= last_next;
        end
    end

    assign pos    = pos_reg;
    assign offset = offset_reg;
    assign last   = last_reg;

endmodule

// ===== sv/separable_complex_scaler.sv =====
// A data item is scaled by one complex multiply for each enabled factor table, then by
// the final multiply with the data, which a zero factor skips.
// The block takes one item at a time, table loads included. The shared complex
// multiply unit (one 33x32 multiplier, four products per complex multiply) sets the rate.
// Reset (rst_n, asynchronous, active low) clears control, counters and configuration;
// the factor table memory is not cleared and must be loaded before it is used.
`include "separable_complex_scaler_macros.svh"

module separable_complex_scaler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dim_sel[1:0], table_index[9:2], value_re[41:10], value_im[73:42], restart[74].
    input  logic [79:0] s_axis_tdata,
    // req_type[0].
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // offset[23:0], out_re[55:24], out_im[87:56].
    output logic [87:0] m_axis_tdata,
    // untouched[0], saturated[1].
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOOK,
        ST_READ,
        ST_MUL,
        ST_FIN,
        ST_FMUL,
        ST_DONE
    } state_t;

    state_t                                  state_reg;
    logic [scs_pkg::DIM_W-1:0]               dim_reg;
    logic signed [scs_pkg::FAC_W-1:0]        f_re_reg;
    logic signed [scs_pkg::FAC_W-1:0]        f_im_reg;
    logic signed [scs_pkg::DATA_W-1:0]       d_re_reg;
    logic signed [scs_pkg::DATA_W-1:0]       d_im_reg;
    logic                                    zero_reg;
    logic signed [scs_pkg::DATA_W-1:0]       r_re_reg;
    logic signed [scs_pkg::DATA_W-1:0]       r_im_reg;
    logic                                    r_clip_reg;
    logic                                    out_valid_reg;
    logic [87:0]                             out_data_reg;
    logic [1:0]                              out_user_reg;
    logic                                    out_last_reg;

    scs_pkg::scs_geom_t                      geom_reg;
    logic                                    conj_reg;
    logic [scs_pkg::NUM_DIMS-1:0]            enable_reg;

    logic                                    in_fire;
    logic                                    load_fire;
    logic                                    data_fire;
    logic [scs_pkg::DIM_W-1:0]               in_dim;
    logic [scs_pkg::IDX_W-1:0]               in_idx;
    logic signed [scs_pkg::DATA_W-1:0]       in_re;
    logic signed [scs_pkg::DATA_W-1:0]       in_im;
    logic                                    in_restart;
    logic                                    out_free;

    logic [scs_pkg::NUM_DIMS-1:0][scs_pkg::IDX_W-1:0] pos;
    logic [scs_pkg::OFF_W-1:0]               offset;
    logic                                    last;

    logic                                    ram_we;
    logic                                    ram_re;
    logic [scs_pkg::ADDR_W-1:0]              ram_raddr;
    logic [2*scs_pkg::DATA_W-1:0]            ram_rdata;
    logic signed [scs_pkg::DATA_W-1:0]       tab_re;
    logic signed [scs_pkg::DATA_W-1:0]       tab_im;

    logic                                    mac_start;
    logic signed [scs_pkg::FAC_W-1:0]        mac_a_re;
    logic signed [scs_pkg::FAC_W-1:0]        mac_a_im;
    logic signed [scs_pkg::DATA_W-1:0]       mac_b_re;
    logic signed [scs_pkg::DATA_W-1:0]       mac_b_im;
    logic                                    mac_busy;
    logic                                    mac_done;
    logic signed [scs_pkg::DATA_W-1:0]       mac_re;
    logic signed [scs_pkg::DATA_W-1:0]       mac_im;
    logic                                    mac_clip;

    assign in_dim     = s_axis_tdata[1:0];
    assign in_idx     = s_axis_tdata[9:2];
    assign in_re      = s_axis_tdata[41:10];
    assign in_im      = s_axis_tdata[73:42];
    assign in_restart = s_axis_tdata[74];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_fire     = in_fire && (s_axis_tuser[0] == scs_pkg::REQ_LOAD);
    assign data_fire     = in_fire && (s_axis_tuser[0] == scs_pkg::REQ_DATA);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign ram_we    = load_fire && (in_dim < scs_pkg::DIM_W'(scs_pkg::NUM_DIMS));
    assign ram_re    = (state_reg == ST_LOOK) && (dim_reg != scs_pkg::DIM_W'(scs_pkg::NUM_DIMS))
                    && enable_reg[dim_reg];
    assign ram_raddr = {dim_reg, pos[dim_reg]};
    assign tab_re    = ram_rdata[2*scs_pkg::DATA_W-1:scs_pkg::DATA_W];
    assign tab_im    = ram_rdata[scs_pkg::DATA_W-1:0];

    always_comb
    begin
        mac_start = 1'b0;
        mac_a_re  = f_re_reg;
        mac_a_im  = f_im_reg;
        mac_b_re  = tab_re;
        mac_b_im  = tab_im;
        if (state_reg == ST_READ)
        begin
            mac_start = 1'b1;
        end
        else if (state_reg == ST_FIN)
        begin
            mac_start = !zero_reg;
            mac_a_im  = conj_reg ? -f_im_reg : f_im_reg;
            mac_b_re  = d_re_reg;
            mac_b_im  = d_im_reg;
        end
    end

    scs_factor_ram u_ram
    (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr ({in_dim, in_idx}),
        .wr_data ({in_re, in_im}),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    scs_index u_index
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (data_fire),
        .restart (in_restart),
        .geom    (geom_reg),
        .pos     (pos),
        .offset  (offset),
        .last    (last)
    );

    scs_cmac u_cmac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .a_re   (mac_a_re),
        .a_im   (mac_a_im),
        .b_re   (mac_b_re),
        .b_im   (mac_b_im),
        .busy   (mac_busy),
        .done   (mac_done),
        .res_re (mac_re),
        .res_im (mac_im),
        .clip   (mac_clip)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.extent <= {scs_pkg::NUM_DIMS{scs_pkg::EXT_W'(1)}};
            geom_reg.stride <= '0;
            conj_reg        <= 1'b0;
            enable_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scs_pkg::REG_EXTENT0: geom_reg.extent[0] <= cfg_data[scs_pkg::EXT_W-1:0];
                scs_pkg::REG_EXTENT1: geom_reg.extent[1] <= cfg_data[scs_pkg::EXT_W-1:0];
                scs_pkg::REG_EXTENT2: geom_reg.extent[2] <= cfg_data[scs_pkg::EXT_W-1:0];
                scs_pkg::REG_STRIDE0: geom_reg.stride[0] <= cfg_data;
                scs_pkg::REG_STRIDE1: geom_reg.stride[1] <= cfg_data;
                scs_pkg::REG_STRIDE2: geom_reg.stride[2] <= cfg_data;
                scs_pkg::REG_CONJ:    conj_reg           <= cfg_data[0];
                scs_pkg::REG_ENABLE:  enable_reg         <= cfg_data[scs_pkg::NUM_DIMS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dim_reg       <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (data_fire)
                    begin
                        state_reg <= ST_LOOK;
                        dim_reg   <= '0;
                        zero_reg  <= 1'b0;
                    end
                end
                ST_LOOK:
                begin
                    if (dim_reg == scs_pkg::DIM_W'(scs_pkg::NUM_DIMS))
                    begin
                        state_reg <= ST_FIN;
                    end
                    else if (enable_reg[dim_reg])
                    begin
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        dim_reg <= dim_reg + scs_pkg::DIM_W'(1);
                    end
                end
                ST_READ:
                begin
                    if (tab_re == '0 && tab_im == '0)
                    begin
                        zero_reg <= 1'b1;
                    end
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (mac_done)
                    begin
                        dim_reg   <= dim_reg + scs_pkg::DIM_W'(1);
                        state_reg <= ST_LOOK;
                    end
                end
                ST_FIN:
                begin
                    state_reg <= zero_reg ? ST_DONE : ST_FMUL;
                end
                ST_FMUL:
                begin
                    if (mac_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_fire)
        begin
            d_re_reg <= in_re;
            d_im_reg <= in_im;
            f_re_reg <= scs_pkg::FAC_W'(1) <<< scs_pkg::FRAC_BITS;
            f_im_reg <= '0;
        end
        if (state_reg == ST_MUL && mac_done)
        begin
            f_re_reg <= scs_pkg::FAC_W'(mac_re);
            f_im_reg <= scs_pkg::FAC_W'(mac_im);
        end
        if (state_reg == ST_FIN && zero_reg)
        begin
            r_re_reg   <= d_re_reg;
            r_im_reg   <= d_im_reg;
            r_clip_reg <= 1'b0;
        end
        if (state_reg == ST_FMUL && mac_done)
        begin
            r_re_reg   <= mac_re;
            r_im_reg   <= mac_im;
            r_clip_reg <= mac_clip;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg <= {r_im_reg, r_re_reg, offset};
            out_user_reg <= {r_clip_reg, zero_reg};
            out_last_reg <= last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    `SCS_ASSERT_SAME(a_mac_in_mul, mac_busy || mac_done, state_reg == ST_MUL || state_reg == ST_FMUL)
    `SCS_ASSERT_NEXT(a_data_leaves_idle, data_fire, state_reg == ST_LOOK)
    `SCS_ASSERT_SAME(a_out_from_done, $rose(m_axis_tvalid), $past(state_reg == ST_DONE))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        bit [23:0]        offset;
        bit signed [31:0] re;
        bit signed [31:0] im;
        bit               untouched;
        bit               saturated;
        bit               last;
    } scaled_t;

    class scaler_scoreboard;
        bit [63:0]   factors[3][256];
        int unsigned position[3];
        bit [8:0]    extent[3];
        bit [23:0]   stride[3];
        bit          conj;
        bit [2:0]    enable;
        scaled_t     pending_q[$];
        int          errors;

        function new();
            foreach (position[d])
            begin
                position[d] = 0;
                extent[d] = 1;
                stride[d] = 0;
            end
            conj = 0;
            enable = 0;
            errors = 0;
        endfunction

        function void write_reg(bit [2:0] idx, bit [23:0] value);
            case (idx)
                scs_pkg::REG_EXTENT0, scs_pkg::REG_EXTENT1, scs_pkg::REG_EXTENT2:
                    extent[idx] = value[8:0];
                scs_pkg::REG_STRIDE0, scs_pkg::REG_STRIDE1, scs_pkg::REG_STRIDE2:
                    stride[idx - scs_pkg::REG_STRIDE0] = value;
                scs_pkg::REG_CONJ:   conj = value[0];
                scs_pkg::REG_ENABLE: enable = value[2:0];
                default: ;
            endcase
        endfunction

        function int unsigned span(int d);
            int unsigned e;
            e = extent[d];
            if (e == 0)
                e = 1;
            if (e > scs_pkg::MAX_EXTENT)
                e = scs_pkg::MAX_EXTENT;
            return e;
        endfunction

        // Rounds a sum of Q27-scaled products to nearest, ties upward.
        function logic signed [71:0] round_q(logic signed [71:0] sum);
            return (sum + 72'sd67108864) >>> scs_pkg::FRAC_BITS;
        endfunction

        function logic signed [71:0] clip32(logic signed [71:0] v, inout bit hit);
            if (v > 72'sd2147483647)
            begin
                hit = 1;
                return 72'sd2147483647;
            end
            if (v < -72'sd2147483648)
            begin
                hit = 1;
                return -72'sd2147483648;
            end
            return v;
        endfunction

        function void note_item(bit req, bit [1:0] sel, bit [7:0] ti,
                                bit signed [31:0] vre, bit signed [31:0] vim, bit rs);
            logic signed [71:0] fre, fim, are, aim, dre, dim;
            logic signed [71:0] nre, nim;
            bit                 zero, clip, inner, last;
            int unsigned        p[3];
            bit [63:0]          off;
            scaled_t            r;
            if (req == scs_pkg::REQ_LOAD)
            begin
                if (sel < scs_pkg::NUM_DIMS)
                    factors[sel][ti] = {vre, vim};
                return;
            end
            if (rs)
                foreach (position[d])
                    position[d] = 0;
            fre = 72'sd134217728;
            fim = '0;
            zero = 0;
            clip = 0;
            inner = 0;
            last = 1;
            off = '0;
            for (int d = 0; d < scs_pkg::NUM_DIMS; d++)
            begin
                p[d] = position[d];
                if (p[d] >= span(d))
                    p[d] = span(d) - 1;
                if (p[d] + 1 < span(d))
                    last = 0;
                off += 64'(p[d]) * 64'(stride[d]);
                if (enable[d])
                begin
                    are = 72'($signed(factors[d][p[d]][63:32]));
                    aim = 72'($signed(factors[d][p[d]][31:0]));
                    if (are == 0 && aim == 0)
                        zero = 1;
                    nre = round_q(fre * are - fim * aim);
                    nim = round_q(fre * aim + fim * are);
                    fre = clip32(nre, inner);
                    fim = clip32(nim, inner);
                end
            end
            dre = 72'(vre);
            dim = 72'(vim);
            if (zero)
            begin
                r.re = vre;
                r.im = vim;
            end
            else
            begin
                if (conj)
                    fim = -fim;
                r.re = 32'(clip32(round_q(fre * dre - fim * dim), clip));
                r.im = 32'(clip32(round_q(fre * dim + fim * dre), clip));
            end
            for (int d = scs_pkg::NUM_DIMS - 1; d >= 0; d--)
            begin
                if (p[d] + 1 < span(d))
                begin
                    position[d] = p[d] + 1;
                    break;
                end
                position[d] = 0;
            end
            r.offset = off[23:0];
            r.untouched = zero;
            r.saturated = clip;
            r.last = last;
            pending_q.push_back(r);
        endfunction

        function void check_result(scaled_t got);
            scaled_t want;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result item, offset %0h", got.offset);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.offset !== want.offset)
            begin
                $error("offset: expected %0h, actual %0h", want.offset, got.offset);
                errors++;
            end
            if (got.re !== want.re)
            begin
                $error("out_re: expected %0d, actual %0d", want.re, got.re);
                errors++;
            end
            if (got.im !== want.im)
            begin
                $error("out_im: expected %0d, actual %0d", want.im, got.im);
                errors++;
            end
            if (got.untouched !== want.untouched)
            begin
                $error("untouched: expected %0b, actual %0b", want.untouched, got.untouched);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    scaler_scoreboard sb = new();
    bit quiet;
    int hold;

    separable_complex_scaler uut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        scaled_t got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.offset = m_axis_tdata[23:0];
            got.re = m_axis_tdata[55:24];
            got.im = m_axis_tdata[87:56];
            got.untouched = m_axis_tuser[0];
            got.saturated = m_axis_tuser[1];
            got.last = m_axis_tlast;
            sb.check_result(got);
            hold = quiet ? 0 : $urandom_range(0, 7);
        end
        else if (hold > 0)
            hold--;
        m_axis_tready <= (hold == 0);
    end

    task automatic send_item(bit req, bit [1:0] sel, bit [7:0] ti,
                             bit [31:0] vre, bit [31:0] vim, bit rs);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {5'b0, rs, vim, vre, ti, sel};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(req, sel, ti, vre, vim, rs);
    endtask

    task automatic write_reg(bit [2:0] idx, bit [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic bit [63:0] pick_factor();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1, 2, 3: return {32'($signed($urandom_range(0, 1 << 28)) - (1 << 27)),
                             32'($signed($urandom_range(0, 1 << 28)) - (1 << 27))};
            4: return {32'h0800_0000, 32'h0};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic bit [31:0] pick_data();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic bit [8:0] pick_extent();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'($urandom_range(257, 511));
            3: return 9'($urandom_range(1, 256));
            default: return 9'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic bit [23:0] pick_stride();
        case ($urandom_range(0, 3))
            0: return 24'h0;
            1: return 24'hff_ffff;
            default: return 24'($urandom());
        endcase
    endfunction

    initial
    begin
        bit [63:0] f;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 0;
        hold = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every table entry gets a value before any element can read it.
        for (int d = 0; d < scs_pkg::NUM_DIMS; d++)
            for (int i = 0; i < scs_pkg::MAX_EXTENT; i++)
            begin
                f = pick_factor();
                send_item(scs_pkg::REQ_LOAD, 2'(d), 8'(i), f[63:32], f[31:0], 1'b0);
            end

        drain();
        write_reg(scs_pkg::REG_EXTENT0, 24'd2);
        write_reg(scs_pkg::REG_EXTENT1, 24'd2);
        write_reg(scs_pkg::REG_EXTENT2, 24'd2);
        write_reg(scs_pkg::REG_STRIDE0, 24'hff_ffff);
        write_reg(scs_pkg::REG_STRIDE1, 24'h1);
        write_reg(scs_pkg::REG_STRIDE2, 24'h0);
        write_reg(scs_pkg::REG_CONJ, 24'd1);
        write_reg(scs_pkg::REG_ENABLE, 24'd7);
        cfg_valid <= 1'b0;
        send_item(scs_pkg::REQ_LOAD, 2'd0, 8'd0, 32'h0800_0000, 32'h0, 1'b0);
        send_item(scs_pkg::REQ_LOAD, 2'd0, 8'd1, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_item(scs_pkg::REQ_LOAD, 2'd1, 8'd0, 32'h8000_0000, 32'h0800_0000, 1'b0);
        send_item(scs_pkg::REQ_LOAD, 2'd1, 8'd1, 32'h0, 32'h0, 1'b0);
        send_item(scs_pkg::REQ_LOAD, 2'd2, 8'd0, 32'h0800_0000, 32'hf800_0000, 1'b0);
        send_item(scs_pkg::REQ_LOAD, 2'd2, 8'd1, 32'h0000_0001, 32'h8000_0000, 1'b0);
        send_item(scs_pkg::REQ_LOAD, 2'd3, 8'hff, 32'h0, 32'h0, 1'b0);
        send_item(scs_pkg::REQ_DATA, 2'd3, 8'hff, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
        send_item(scs_pkg::REQ_DATA, 2'd0, 8'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_item(scs_pkg::REQ_DATA, 2'd0, 8'd0, 32'h0, 32'hffff_ffff, 1'b0);
        send_item(scs_pkg::REQ_DATA, 2'd0, 8'd0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_item(scs_pkg::REQ_DATA, 2'd0, 8'd0, 32'h1, 32'h1, 1'b0);
        send_item(scs_pkg::REQ_DATA, 2'd0, 8'd0, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_item(scs_pkg::REQ_DATA, 2'd0, 8'd0, 32'h1234_5678, 32'hedcb_a987, 1'b1);
        for (int i = 0; i < 9; i++)
            send_item(scs_pkg::REQ_DATA, 2'd0, 8'd0, pick_data(), pick_data(), 1'b0);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            quiet = (phase % 3 == 2);
            write_reg(scs_pkg::REG_EXTENT0, 24'(phase == 0 ? 9'd256 : pick_extent()));
            write_reg(scs_pkg::REG_EXTENT1, 24'(phase == 0 ? 9'd0 : pick_extent()));
            write_reg(scs_pkg::REG_EXTENT2, 24'(phase == 0 ? 9'd511 : pick_extent()));
            write_reg(scs_pkg::REG_STRIDE0, pick_stride());
            write_reg(scs_pkg::REG_STRIDE1, pick_stride());
            write_reg(scs_pkg::REG_STRIDE2, pick_stride());
            write_reg(scs_pkg::REG_CONJ, 24'(phase % 2));
            write_reg(scs_pkg::REG_ENABLE,
                      24'(phase == 7 ? 3'd0 : 3'($urandom_range(0, 7))));
            cfg_valid <= 1'b0;
            for (int n = 0; n < 100; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    f = pick_factor();
                    send_item(scs_pkg::REQ_LOAD, 2'($urandom_range(0, 3)), 8'($urandom()),
                              f[63:32], f[31:0], 1'($urandom()));
                end
                else
                    send_item(scs_pkg::REQ_DATA, 2'($urandom()), 8'($urandom()), pick_data(),
                              pick_data(), $urandom_range(0, 15) == 0);
            end
        end

        drain();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/scs_pkg.sv
sv/scs_factor_ram.sv
sv/scs_cmac.sv
sv/scs_index.sv
sv/separable_complex_scaler.sv
tb/testbench.sv
